// ----- design/sm4c_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SM4 CBC encryptor package
// Shared constants, S-box, linear transforms and control types.
// ----------------------------------------------------------------------------
package sm4c_pkg;

   localparam int unsigned ROUNDS_DEF = 32;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned HALF_W     = 64;
   localparam int unsigned BLOCK_W    = 128;
   localparam int unsigned CSR_IDX_W  = 2;

   // Key schedule system parameters
   localparam logic [WORD_W-1:0] FK0 = 32'hA3B1BAC6;
   localparam logic [WORD_W-1:0] FK1 = 32'h56AA3350;
   localparam logic [WORD_W-1:0] FK2 = 32'h677D9197;
   localparam logic [WORD_W-1:0] FK3 = 32'hB27022DC;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KEY_HIGH = 2'd0,
      REG_KEY_LOW  = 2'd1,
      REG_IV_HIGH  = 2'd2,
      REG_IV_LOW   = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXPAND = 4'b0010,
      ST_ROUND  = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   // Control bundle from the sequencer to the round core
   typedef struct packed {
      logic load_key;
      logic load_blk;
      logic advance;
      logic key_mode;
   } core_ctrl_type;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,
      8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
      8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,
      8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,
      8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
      8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,
      8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,
      8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
      8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,
      8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,
      8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
      8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,
      8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,
      8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
      8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,
      8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,
      8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input int unsigned n);
      return (x << n) | (x >> (WORD_W - n));
   endfunction

   // Byte-wise S-box substitution
   function automatic logic [WORD_W-1:0] tau(input logic [WORD_W-1:0] x);
      return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
   endfunction

   // Linear transform of the data rounds
   function automatic logic [WORD_W-1:0] lin_enc(input logic [WORD_W-1:0] b);
      return b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
   endfunction

   // Linear transform of the key schedule
   function automatic logic [WORD_W-1:0] lin_key(input logic [WORD_W-1:0] b);
      return b ^ rotl32(b, 13) ^ rotl32(b, 23);
   endfunction

   // CK word: byte j of word i is (4i+j)*7 mod 256
   function automatic logic [WORD_W-1:0] ck_word(input logic [4:0] idx);
      logic [WORD_W-1:0] w;
      logic [7:0]        base;
      w    = '0;
      base = {1'b0, idx, 2'b00};
      for (int j = 0; j < 4; j++) begin
         w = {w[23:0], 8'((base + 8'(j)) * 8'd7)};
      end
      return w;
   endfunction

endpackage
`default_nettype wire

// ----- design/sm4c_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SM4 CBC encryptor channels
// Valid/ready interfaces for plaintext requests and ciphertext responses.
// ----------------------------------------------------------------------------
interface sm4c_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_high;
   logic [63:0] data_low;
   logic        first_block;

   modport source (output valid, output data_high, output data_low,
                   output first_block, input ready);
   modport sink   (input valid, input data_high, input data_low,
                   input first_block, output ready);
endinterface

interface sm4c_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] cipher_high;
   logic [63:0] cipher_low;

   modport source (output valid, output cipher_high, output cipher_low, input ready);
   modport sink   (input valid, input cipher_high, input cipher_low, output ready);
endinterface
`default_nettype wire

// ----- design/sm4_cbc_encryptor_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a request transfer loads the round core; the key schedule runs first
//   when the round keys are not valid, then the data rounds, then the response.
// Flow: one block at a time through the shared round core and the round key
//   memory read port; a new request is taken only once the response is loaded.
// Reset: synchronous, active high; clears key, IV, chaining value, key-valid
//   flag and handshakes. The round key memory needs no clearing pass.
// ----------------------------------------------------------------------------
// SM4 CBC encryptor top level
// Sequencer, configuration registers, chaining value and response register.
// ----------------------------------------------------------------------------
module sm4_cbc_encryptor_unit
   import sm4c_pkg::*;
#(
   parameter int unsigned ROUNDS = ROUNDS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   sm4c_req_if.sink                  req_chan,
   sm4c_rsp_if.source                rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [HALF_W-1:0]    csr_wdata
);

   localparam int unsigned RND_W = $clog2(ROUNDS);
   localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

   state_type          state_ff, state_in;
   logic [RND_W-1:0]   cnt_ff, cnt_in;
   logic               keys_ready_ff, keys_ready_in;
   logic [HALF_W-1:0]  key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic [BLOCK_W-1:0] chain_ff;
   logic [BLOCK_W-1:0] blk_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0] rsp_data_ff;

   logic               req_fire;
   logic [BLOCK_W-1:0] blk_in;
   logic [BLOCK_W-1:0] key_init;
   logic               out_load;
   core_ctrl_type      ctrl;
   logic               rk_we;
   logic [RND_W-1:0]   rk_raddr;
   logic [WORD_W-1:0]  rk_rdata;
   logic [WORD_W-1:0]  new_word;
   logic [BLOCK_W-1:0] core_result;
   logic [RND_W-1:0]   cnt_next;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid & req_chan.ready;

   // Chain plaintext with IV or previous ciphertext
   assign blk_in = {req_chan.data_high, req_chan.data_low} ^
                   (req_chan.first_block ? {iv_high_ff, iv_low_ff} : chain_ff);
   assign key_init = {key_high_ff, key_low_ff} ^ {FK0, FK1, FK2, FK3};
   assign cnt_next = (cnt_ff == LAST_RND) ? '0 : cnt_ff + RND_W'(1);

   // Sequence key expansion and data rounds
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      keys_ready_in = keys_ready_ff;
      ctrl          = '0;
      rk_we         = 1'b0;
      rk_raddr      = '0;
      out_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in = '0;
               if (keys_ready_ff) begin
                  ctrl.load_blk = 1'b1;
                  state_in      = ST_ROUND;
               end else begin
                  ctrl.load_key = 1'b1;
                  state_in      = ST_EXPAND;
               end
            end
         end
         ST_EXPAND: begin
            ctrl.advance  = 1'b1;
            ctrl.key_mode = 1'b1;
            rk_we         = 1'b1;
            cnt_in        = cnt_next;
            if (cnt_ff == LAST_RND) begin
               ctrl.load_blk = 1'b1;
               keys_ready_in = 1'b1;
               state_in      = ST_ROUND;
            end
         end
         ST_ROUND: begin
            ctrl.advance = 1'b1;
            rk_raddr     = cnt_next;
            cnt_in       = cnt_next;
            if (cnt_ff == LAST_RND) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Any register write invalidates the round keys
      if (csr_we) begin
         keys_ready_in = 1'b0;
      end
   end

   // Hold the response until transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and chaining registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         keys_ready_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         chain_ff      <= '0;
         key_high_ff   <= '0;
         key_low_ff    <= '0;
         iv_high_ff    <= '0;
         iv_low_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         keys_ready_ff <= keys_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (out_load) begin
            chain_ff <= core_result;
         end
         if (csr_we) begin
            unique case (csr_index)
               REG_KEY_HIGH: key_high_ff <= csr_wdata;
               REG_KEY_LOW:  key_low_ff  <= csr_wdata;
               REG_IV_HIGH:  iv_high_ff  <= csr_wdata;
               REG_IV_LOW:   iv_low_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         blk_ff <= blk_in;
      end
      if (out_load) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.cipher_high = rsp_data_ff[127:64];
   assign rsp_chan.cipher_low  = rsp_data_ff[63:0];

   sm4c_core #(
      .RND_W (RND_W)
   ) u_core (
      .clock    (clock),
      .ctrl     (ctrl),
      .rnd      (cnt_ff),
      .key_init (key_init),
      .blk      ((state_ff == ST_IDLE) ? blk_in : blk_ff),
      .rk       (rk_rdata),
      .new_word (new_word),
      .result   (core_result)
   );

   sm4c_rk_ram #(
      .DEPTH  (ROUNDS),
      .ADDR_W (RND_W)
   ) u_rk_ram (
      .clock   (clock),
      .wr_en   (rk_we),
      .wr_addr (cnt_ff),
      .wr_data (new_word),
      .rd_addr (rk_raddr),
      .rd_data (rk_rdata)
   );

endmodule
`default_nettype wire

// ----- design/sm4c_rk_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SM4 round key memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sm4c_rk_ram
   import sm4c_pkg::*;
#(
   parameter int unsigned DEPTH  = ROUNDS_DEF,
   parameter int unsigned ADDR_W = $clog2(ROUNDS_DEF)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // Write one round key, read one every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- design/sm4c_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SM4 round core
// Four-word shift state and one shared round function, used for key
// expansion (L' with CK) and for data rounds (L with the stored round key).
// ----------------------------------------------------------------------------
module sm4c_core
   import sm4c_pkg::*;
#(
   parameter int unsigned RND_W = $clog2(ROUNDS_DEF)
) (
   input  wire logic               clock,
   input  wire core_ctrl_type      ctrl,
   input  wire logic [RND_W-1:0]   rnd,
   input  wire logic [BLOCK_W-1:0] key_init,
   input  wire logic [BLOCK_W-1:0] blk,
   input  wire logic [WORD_W-1:0]  rk,
   output logic      [WORD_W-1:0]  new_word,
   output logic      [BLOCK_W-1:0] result
);

   logic [WORD_W-1:0] x_ff [4];
   logic [WORD_W-1:0] mix;
   logic [WORD_W-1:0] sub;
   logic [WORD_W-1:0] lin;

   // Shared round function
   always_comb begin
      mix = x_ff[1] ^ x_ff[2] ^ x_ff[3] ^
            (ctrl.key_mode ? ck_word(5'(rnd)) : rk);
      sub = tau(mix);
      lin = ctrl.key_mode ? lin_key(sub) : lin_enc(sub);
      new_word = x_ff[0] ^ lin;
   end

   // Load a fresh state or advance by one round
   always_ff @(posedge clock) begin
      if (ctrl.load_blk) begin
         x_ff[0] <= blk[127:96];
         x_ff[1] <= blk[95:64];
         x_ff[2] <= blk[63:32];
         x_ff[3] <= blk[31:0];
      end else if (ctrl.load_key) begin
         x_ff[0] <= key_init[127:96];
         x_ff[1] <= key_init[95:64];
         x_ff[2] <= key_init[63:32];
         x_ff[3] <= key_init[31:0];
      end else if (ctrl.advance) begin
         x_ff[0] <= x_ff[1];
         x_ff[1] <= x_ff[2];
         x_ff[2] <= x_ff[3];
         x_ff[3] <= new_word;
      end
   end

   // Reverse word order for the final output
   assign result = {x_ff[3], x_ff[2], x_ff[1], x_ff[0]};

endmodule
`default_nettype wire

// ----- design/sm4c_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SM4 CBC encryptor port checker
// Checks handshake behavior and block latency seen at the top level ports.
// ----------------------------------------------------------------------------
module sm4c_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] cipher_high,
   input wire logic [63:0] cipher_low
);

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Keep a stalled response payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(cipher_high) && $stable(cipher_low))
      else $error("response payload changed while stalled");

   // Take one block at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a block is in flight");

   // A new response only after a full round sequence
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready, 32))
      else $error("response appeared before the rounds finished");

endmodule

bind sm4_cbc_encryptor_unit sm4c_checker u_sm4c_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .cipher_high (rsp_chan.cipher_high),
   .cipher_low  (rsp_chan.cipher_low)
);
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM4 CBC encryptor testbench
// Drives plaintext blocks and key/IV settings into the encryptor, predicts
// every ciphertext block with an independent SM4 key schedule and cipher,
// and checks the responses in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned LIMIT_CYCLES = 1_000_000;
   localparam int unsigned PHASES       = 10;
   localparam int unsigned PHASE_BLOCKS = 165;

   // SM4 substitution table
   localparam logic [7:0] SUB_TABLE [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // Tracks key, IV and chaining value; predicts and checks ciphertext blocks
   class cbc_cipher_tracker;
      logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
      logic [63:0]  chain_hi, chain_lo;
      logic [31:0]  sched_keys [32];
      bit           sched_valid;
      logic [127:0] expected_cipher [$];
      int unsigned  err_count;

      function new();
         key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
         chain_hi = '0; chain_lo = '0;
         sched_valid = 1'b0;
         err_count = 0;
      endfunction

      function logic [31:0] rotl_word(logic [31:0] x, int unsigned n);
         return (x << n) | (x >> (32 - n));
      endfunction

      function logic [31:0] sub_word(logic [31:0] x);
         return {SUB_TABLE[x[31:24]], SUB_TABLE[x[23:16]],
                 SUB_TABLE[x[15:8]], SUB_TABLE[x[7:0]]};
      endfunction

      // Byte j of word i is (4i+j)*7 mod 256
      function logic [31:0] round_const(int unsigned i);
         logic [31:0] w;
         w = '0;
         for (int unsigned j = 0; j < 4; j++) begin
            w = {w[23:0], 8'(((4 * i) + j) * 7)};
         end
         return w;
      endfunction

      function void expand_keys();
         logic [31:0] k [4];
         logic [31:0] b;
         logic [31:0] nk;
         k[0] = key_hi[63:32] ^ sm4c_pkg::FK0;
         k[1] = key_hi[31:0]  ^ sm4c_pkg::FK1;
         k[2] = key_lo[63:32] ^ sm4c_pkg::FK2;
         k[3] = key_lo[31:0]  ^ sm4c_pkg::FK3;
         for (int unsigned i = 0; i < 32; i++) begin
            b  = sub_word(k[(i + 1) % 4] ^ k[(i + 2) % 4] ^ k[(i + 3) % 4] ^ round_const(i));
            nk = k[i % 4] ^ b ^ rotl_word(b, 13) ^ rotl_word(b, 23);
            sched_keys[i] = nk;
            k[i % 4] = nk;
         end
         sched_valid = 1'b1;
      endfunction

      // Any register write forces a new key schedule; the chain is kept
      function void note_write(sm4c_pkg::csr_index_type idx, logic [63:0] value);
         case (idx)
            sm4c_pkg::REG_KEY_HIGH: key_hi = value;
            sm4c_pkg::REG_KEY_LOW:  key_lo = value;
            sm4c_pkg::REG_IV_HIGH:  iv_hi  = value;
            sm4c_pkg::REG_IV_LOW:   iv_lo  = value;
            default: return;
         endcase
         sched_valid = 1'b0;
      endfunction

      function void note_plaintext(logic [63:0] data_hi, logic [63:0] data_lo, logic first);
         logic [31:0] x [4];
         logic [31:0] b;
         logic [31:0] nx;
         logic [63:0] hi, lo;
         if (!sched_valid) expand_keys();
         hi = data_hi ^ (first ? iv_hi : chain_hi);
         lo = data_lo ^ (first ? iv_lo : chain_lo);
         x[0] = hi[63:32]; x[1] = hi[31:0]; x[2] = lo[63:32]; x[3] = lo[31:0];
         for (int unsigned i = 0; i < 32; i++) begin
            b  = sub_word(x[1] ^ x[2] ^ x[3] ^ sched_keys[i]);
            nx = x[0] ^ b ^ rotl_word(b, 2) ^ rotl_word(b, 10)
                 ^ rotl_word(b, 18) ^ rotl_word(b, 24);
            x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
         end
         chain_hi = {x[3], x[2]};
         chain_lo = {x[1], x[0]};
         expected_cipher.push_back({chain_hi, chain_lo});
      endfunction

      function void check_ciphertext(logic [63:0] cipher_hi, logic [63:0] cipher_lo);
         logic [127:0] want;
         if (expected_cipher.size() == 0) begin
            $error("ciphertext %h_%h with no block outstanding", cipher_hi, cipher_lo);
            err_count++;
            return;
         end
         want = expected_cipher.pop_front();
         if (cipher_hi !== want[127:64]) begin
            $error("cipher_high: expected %h, actual %h", want[127:64], cipher_hi);
            err_count++;
         end
         if (cipher_lo !== want[63:0]) begin
            $error("cipher_low: expected %h, actual %h", want[63:0], cipher_lo);
            err_count++;
         end
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               csr_we;
   logic [sm4c_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [sm4c_pkg::HALF_W-1:0]        csr_wdata;
   bit                                 idle_on;
   cbc_cipher_tracker                  tracker;

   sm4c_req_if req_chan ();
   sm4c_rsp_if rsp_chan ();

   sm4_cbc_encryptor_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones, none while idling is off
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!idle_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Random half block, now and then an extreme pattern
   function automatic logic [63:0] rand_half();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return '1;
         2:       return 64'h1 << $urandom_range(0, 63);
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic write_reg(sm4c_pkg::csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.note_write(idx, value);
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Present one block after a random gap and hold it until the transfer
   task automatic send_block(logic [63:0] data_hi, logic [63:0] data_lo, logic first);
      int unsigned gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid     <= 1'b0;
         req_chan.data_high <= {$urandom(), $urandom()};
      end
      @(negedge clock);
      req_chan.valid       <= 1'b1;
      req_chan.data_high   <= data_hi;
      req_chan.data_low    <= data_lo;
      req_chan.first_block <= first;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      tracker.note_plaintext(data_hi, data_lo, first);
   endtask

   // Drop valid and wait until every predicted block has come back
   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (tracker.expected_cipher.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_settings(int unsigned style);
      case (style)
         0: begin
            write_reg(sm4c_pkg::REG_KEY_HIGH, '0);
            write_reg(sm4c_pkg::REG_KEY_LOW,  '0);
            write_reg(sm4c_pkg::REG_IV_HIGH,  '0);
            write_reg(sm4c_pkg::REG_IV_LOW,   '0);
         end
         1: begin
            write_reg(sm4c_pkg::REG_KEY_HIGH, '1);
            write_reg(sm4c_pkg::REG_KEY_LOW,  '1);
            write_reg(sm4c_pkg::REG_IV_HIGH,  '1);
            write_reg(sm4c_pkg::REG_IV_LOW,   '1);
         end
         2: begin
            write_reg(sm4c_pkg::REG_KEY_HIGH, rand_half());
            write_reg(sm4c_pkg::REG_KEY_LOW,  rand_half());
            write_reg(sm4c_pkg::REG_IV_HIGH,  rand_half());
            write_reg(sm4c_pkg::REG_IV_LOW,   rand_half());
         end
         default: begin
            // Rewrite a random subset in random order
            repeat ($urandom_range(1, 4)) begin
               write_reg(sm4c_pkg::csr_index_type'($urandom_range(0, 3)), rand_half());
            end
         end
      endcase
      end_writes();
   endtask

   // Response side: stall at random, check each transfer
   initial begin : response_side
      int unsigned stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            tracker.check_ciphertext(rsp_chan.cipher_high, rsp_chan.cipher_low);
            stall_left = pick_gap();
         end
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase_sent;
      int unsigned msg_len;
      bit          well_formed;
      tracker              = new();
      idle_on              = 1'b1;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = sm4c_pkg::REG_KEY_HIGH;
      csr_wdata            = '0;
      req_chan.valid       = 1'b0;
      req_chan.data_high   = '0;
      req_chan.data_low    = '0;
      req_chan.first_block = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Chain from the zero value after reset, with the reset key and IV
      send_block('0, '0, 1'b0);
      send_block('1, '1, 1'b0);
      send_block('1, '1, 1'b1);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
      drain();

      // Standard key and plaintext, then chaining on the result
      write_reg(sm4c_pkg::REG_KEY_HIGH, 64'h0123456789abcdef);
      write_reg(sm4c_pkg::REG_KEY_LOW,  64'hfedcba9876543210);
      write_reg(sm4c_pkg::REG_IV_HIGH,  '0);
      write_reg(sm4c_pkg::REG_IV_LOW,   '0);
      end_writes();
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
      send_block('0, '0, 1'b0);
      send_block('1, '1, 1'b0);
      drain();

      // A single write re-expands the keys but keeps the chain
      write_reg(sm4c_pkg::REG_IV_HIGH, '1);
      end_writes();
      send_block(rand_half(), rand_half(), 1'b0);
      send_block(rand_half(), rand_half(), 1'b1);
      drain();

      // All-ones key and IV
      load_settings(1);
      send_block('0, '0, 1'b1);
      send_block('1, '1, 1'b0);
      send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
      send_block('1, '1, 1'b1);
      drain();

      write_reg(sm4c_pkg::REG_KEY_LOW, '0);
      end_writes();
      send_block(64'h8000000000000000, 64'h1, 1'b1);
      send_block(64'h1, 64'h8000000000000000, 1'b0);
      drain();

      // Random phases: mostly messages that start with a first block
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         load_settings(phase % 4 == 0 ? 2 : (phase % 5 == 1 ? 0 : 3));
         idle_on    = (phase % 4 != 3);
         phase_sent = 0;
         while (phase_sent < PHASE_BLOCKS) begin
            well_formed = ($urandom_range(0, 99) < 85);
            msg_len     = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                      : $urandom_range(1, 8);
            for (int unsigned n = 0; n < msg_len; n++) begin
               if (well_formed) send_block(rand_half(), rand_half(), n == 0);
               else send_block(rand_half(), rand_half(), 1'($urandom_range(0, 1)));
               phase_sent++;
            end
         end
         drain();
      end

      repeat (40) @(posedge clock);
      if (tracker.expected_cipher.size() != 0) begin
         $error("%0d ciphertext blocks never arrived", tracker.expected_cipher.size());
         tracker.err_count++;
      end
      if (tracker.err_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
